FILE: src/msb_first_bit_field_packer_top_defines.svh
// assertion macros for the bit field packer
// used by msb_first_bit_field_packer_top, expects clk and rst_n in scope
`ifndef MSB_FIRST_BIT_FIELD_PACKER_TOP_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_PACKER_TOP_DEFINES_SVH

`ifndef SYNTH
`define BFP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("bfp assertion failed");
`define BFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfp assertion failed");
`else
`define BFP_ASSERT(lbl, expr)
`define BFP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/bfp_pkg.sv
// shared types, constants and the width mask function of the bit field packer
// no dependencies
package bfp_pkg;

  localparam int ACT_W = 2;
  localparam int WID_W = 6;
  localparam int VAL_W = 32;
  localparam int POS_W = 14;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEEK  = 2'd2;

  localparam logic [WID_W-1:0] MAX_WIDTH = 6'd32;
  localparam logic [7:0]       BYTE_ONES = 8'hFF;

  typedef struct packed {
    logic load;
    logic wr_step;
    logic rd_step;
  } bfp_ctl_t;

  function automatic logic [VAL_W-1:0] width_mask(input logic [WID_W-1:0] w);
    logic [VAL_W-1:0] m;
    if (w >= MAX_WIDTH) begin
      m = {VAL_W{1'b1}};
    end else begin
      m = (VAL_W'(1) << w) - VAL_W'(1);
    end
    return m;
  endfunction

endpackage

FILE: src/bfp_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module bfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bfp_digit.sv
// byte-serial shift unit: aligns write data and gathers read data one byte per beat
// depends on bfp_pkg
module bfp_digit (
  input  logic                      clk,
  input  bfp_pkg::bfp_ctl_t         ctl,
  input  logic [bfp_pkg::VAL_W-1:0] value,
  input  logic [bfp_pkg::WID_W-1:0] width,
  input  logic [2:0]                pad,
  input  logic [7:0]                rdata,
  output logic [7:0]                wr_byte,
  output logic [bfp_pkg::VAL_W-1:0] result
);
  import bfp_pkg::*;

  logic [VAL_W+7:0] sr_r;
  logic [VAL_W+7:0] acc_r;
  logic [2:0]       pad_r;
  logic [WID_W-1:0] w_r;
  logic [VAL_W+7:0] acc_sh;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sr_r  <= {8'b0, value & width_mask(width)} << pad;
      acc_r <= '0;
      pad_r <= pad;
      w_r   <= width;
    end else begin
      if (ctl.wr_step) begin
        sr_r <= sr_r >> 8;
      end
      if (ctl.rd_step) begin
        acc_r <= {acc_r[VAL_W-1:0], rdata};
      end
    end
  end

  assign acc_sh  = acc_r >> pad_r;
  assign wr_byte = (rdata | sr_r[7:0]) & BYTE_ONES;
  assign result  = acc_sh[VAL_W-1:0] & width_mask(w_r);

endmodule

FILE: src/msb_first_bit_field_packer_top.sv
// Bit field packer: a byte store with a bit cursor; each beat writes (ORs in), reads or
// seeks, MSB first, bit 7 of a byte first. A write or read touches n store bytes (1 to 5,
// set by cursor offset and width); a write does one read-modify-write of the ram per byte,
// with the write in the cycle after the read, while a read only reads; seeks, refused,
// zero-width and unused beats go straight to the done state. After reset a clearing
// pass zeroes the store before the first beat is taken.
// depends on bfp_pkg, bfp_ram, bfp_digit and the defines header
`include "msb_first_bit_field_packer_top_defines.svh"

module msb_first_bit_field_packer_top #(
  parameter int STORE_BYTES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bfp_pkg::ACT_W-1:0] in_action,
  input  logic [bfp_pkg::WID_W-1:0] in_width,
  input  logic [bfp_pkg::VAL_W-1:0] in_value,
  input  logic [bfp_pkg::POS_W-1:0] in_position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bfp_pkg::VAL_W-1:0] out_read_value,
  output logic                      out_fault
);
  import bfp_pkg::*;

  localparam int SBITS = STORE_BYTES * 8;
  localparam int CW    = $clog2(SBITS + 1);
  localparam int AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    cursor_r, cursor_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    waddr_r, waddr_nxt;
  logic [2:0]       left_r, left_nxt;
  logic             rv_r, rv_nxt;
  logic             is_wr_r, is_wr_nxt;
  logic             rdres_r, rdres_nxt;
  logic             fault_r, fault_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_read_value_r, out_read_value_nxt;
  logic             out_fault_r, out_fault_nxt;

  logic             accept;
  logic             acc_ok;
  logic [6:0]       ow;
  logic [2:0]       nbytes;
  logic [2:0]       pad;
  logic [AW-1:0]    base;
  bfp_ctl_t         ctl;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  logic [7:0]       wr_byte;
  logic [VAL_W-1:0] dig_result;

  assign in_ready       = (state_r == ST_IDLE);
  assign accept         = in_valid & in_ready;
  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_fault      = out_fault_r;

  assign ow     = 7'(cursor_r[2:0]) + 7'(in_width);
  assign nbytes = 3'((ow + 7'd7) >> 3);
  assign pad    = 3'(7'd0 - ow);
  assign base   = AW'(cursor_r >> 3);
  assign acc_ok = (in_width <= MAX_WIDTH) &&
                  ((32'(cursor_r) + 32'(in_width)) <= 32'(SBITS));

  always_comb begin
    state_nxt          = state_r;
    cursor_nxt         = cursor_r;
    addr_nxt           = addr_r;
    waddr_nxt          = waddr_r;
    left_nxt           = left_r;
    rv_nxt             = 1'b0;
    is_wr_nxt          = is_wr_r;
    rdres_nxt          = rdres_r;
    fault_nxt          = fault_r;
    out_valid_nxt      = out_valid_r & ~out_ready;
    out_read_value_nxt = out_read_value_r;
    out_fault_nxt      = out_fault_r;
    ctl                = '0;
    ram_we             = 1'b0;
    ram_waddr          = waddr_r;
    ram_wdata          = wr_byte;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = '0;
        addr_nxt  = AW'(addr_r + AW'(1));
        if (addr_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          fault_nxt = 1'b0;
          rdres_nxt = 1'b0;
          state_nxt = ST_DONE;
          unique case (in_action)
            ACT_WRITE, ACT_READ: begin
              if (!acc_ok) begin
                fault_nxt = 1'b1;
              end else if (in_width != '0) begin
                ctl.load   = 1'b1;
                state_nxt  = ST_RUN;
                cursor_nxt = CW'(32'(cursor_r) + 32'(in_width));
                left_nxt   = nbytes;
                is_wr_nxt  = (in_action == ACT_WRITE);
                rdres_nxt  = (in_action == ACT_READ);
                addr_nxt   = (in_action == ACT_WRITE) ?
                             AW'(base + AW'(nbytes - 3'd1)) : base;
              end
            end
            ACT_SEEK: begin
              if (32'(in_position) > 32'(SBITS)) begin
                fault_nxt = 1'b1;
              end else begin
                cursor_nxt = CW'(in_position);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (left_r != '0) begin
          rv_nxt    = 1'b1;
          left_nxt  = left_r - 3'd1;
          waddr_nxt = addr_r;
          addr_nxt  = is_wr_r ? AW'(addr_r - AW'(1)) : AW'(addr_r + AW'(1));
        end
        if (rv_r) begin
          ctl.wr_step = is_wr_r;
          ctl.rd_step = ~is_wr_r;
          ram_we      = is_wr_r;
          if (left_r == '0) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_read_value_nxt = rdres_r ? dig_result : '0;
          out_fault_nxt      = fault_r;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cursor_r    <= '0;
      addr_r      <= '0;
      left_r      <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      fault_r     <= 1'b0;
      rdres_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      addr_r      <= addr_nxt;
      left_r      <= left_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      fault_r     <= fault_nxt;
      rdres_r     <= rdres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    waddr_r          <= waddr_nxt;
    is_wr_r          <= is_wr_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_fault_r      <= out_fault_nxt;
  end

  bfp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  bfp_digit u_digit (
    .clk     (clk),
    .ctl     (ctl),
    .value   (in_value),
    .width   (in_width),
    .pad     (pad),
    .rdata   (ram_rdata),
    .wr_byte (wr_byte),
    .result  (dig_result)
  );

  `BFP_ASSERT(a_cursor_range, 32'(cursor_r) <= 32'(SBITS))
  `BFP_ASSERT(a_left_range, left_r <= 3'd5)
  `BFP_ASSERT(a_no_ram_write_on_read, !(state_r == ST_RUN && ram_we && !is_wr_r))
  `BFP_ASSERT(a_fault_zero, !(out_valid && out_fault && out_read_value != '0))
  `BFP_ASSERT_NEXT(a_run_done, state_r == ST_RUN && rv_r && left_r == 3'd0, state_r == ST_DONE)

endmodule
